>>> src/cpr_pkg.sv
// cpr_pkg: shared types and constants of the crc checked packet receiver
// used by cpr_csr, cpr_crc_step and the top level
package cpr_pkg;

   localparam int HEADER_BYTES = 20;
   localparam int HDR_CNT_W    = 5;
   localparam int CSR_ADDR_W   = 4;

   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [31:0] MAGIC_RESET   = 32'h474D_4945;
   localparam logic [15:0] LENGTH_RESET  = 16'd27648;
   localparam logic [15:0] TIMEOUT_RESET = 16'd15000;
   localparam logic [7:0]  CLASS_RESET   = 8'd1;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_MAGIC    = 3'd1,
      ST_BAD_CLASS    = 3'd2,
      ST_BAD_LENGTH   = 3'd3,
      ST_TIMEOUT      = 3'd4,
      ST_CRC_MISMATCH = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_MAGIC   = 2'd0,
      REG_LENGTH  = 2'd1,
      REG_TIMEOUT = 2'd2,
      REG_CLASS   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [31:0] packet_magic;
      logic [15:0] payload_length;
      logic [15:0] timeout_ticks;
      logic [7:0]  max_class;
   } cfg_type;

endpackage

>>> src/cpr_if.sv
// cpr_if: valid/ready channel interfaces for request words and result words
// depends on nothing but the standard handshake
interface cpr_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface cpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] image_id;
   logic [7:0]  expected_class;
   logic [31:0] header_value;
   logic [31:0] computed_crc;

   modport source (output valid, output status, output image_id, output expected_class,
                   output header_value, output computed_crc, input ready);
   modport sink (input valid, input status, input image_id, input expected_class,
                 input header_value, input computed_crc, output ready);
endinterface

>>> src/cpr_csr.sv
// cpr_csr: apb-style configuration registers of the packet receiver
// depends on cpr_pkg for the register map and reset values
module cpr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cpr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output cpr_pkg::cfg_type              cfg
);

   cpr_pkg::cfg_type      cfg_ff, cfg_in;
   cpr_pkg::reg_index_type idx;
   logic                  wr_en;

   assign idx        = cpr_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            cpr_pkg::REG_MAGIC:   cfg_in.packet_magic   = csr_pwdata;
            cpr_pkg::REG_LENGTH:  cfg_in.payload_length = csr_pwdata[15:0];
            cpr_pkg::REG_TIMEOUT: cfg_in.timeout_ticks  = csr_pwdata[15:0];
            cpr_pkg::REG_CLASS:   cfg_in.max_class      = csr_pwdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         cpr_pkg::REG_MAGIC:   csr_prdata = cfg_ff.packet_magic;
         cpr_pkg::REG_LENGTH:  csr_prdata = {16'd0, cfg_ff.payload_length};
         cpr_pkg::REG_TIMEOUT: csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         cpr_pkg::REG_CLASS:   csr_prdata = {24'd0, cfg_ff.max_class};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_magic   <= cpr_pkg::MAGIC_RESET;
         cfg_ff.payload_length <= cpr_pkg::LENGTH_RESET;
         cfg_ff.timeout_ticks  <= cpr_pkg::TIMEOUT_RESET;
         cfg_ff.max_class      <= cpr_pkg::CLASS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/cpr_crc_step.sv
// cpr_crc_step: one byte of reflected crc-32 update
// depends on cpr_pkg for the polynomial
module cpr_crc_step (
   input  logic [31:0] crc_in,
   input  logic [7:0]  data,
   output logic [31:0] crc_out
);

   always_comb begin
      logic [31:0] c;
      c = crc_in ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? cpr_pkg::CRC_POLY : 32'd0);
      end
      crc_out = c;
   end

endmodule

>>> src/crc_checked_packet_receiver.sv
// Receiver for framed packets with a crc-32 check. Each request word is either a received
// byte or one time tick. A 20-byte little-endian header (magic, image id, class byte, three
// spare bytes, payload length, payload crc) is collected and checked against the
// configuration registers; a bad header gives one result and the next bytes start a new
// header. Payload bytes run through a reflected crc-32, ticks without a byte count toward
// the payload timeout. One result word leaves per finished packet. Each request word lands
// in an input register and the byte crc update and header checks sit between that
// register and the result register, so a word can be taken every cycle while the result
// is drained. Depends on cpr_pkg, cpr_if, cpr_csr and cpr_crc_step.
module crc_checked_packet_receiver (
   input  logic                           clock,
   input  logic                           reset,
   cpr_req_if.sink                        req_chan,
   cpr_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cpr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'b01,
      PH_PAYLOAD = 2'b10
   } phase_type;

   localparam logic [cpr_pkg::HDR_CNT_W-1:0] LAST_IDX =
      cpr_pkg::HDR_CNT_W'(cpr_pkg::HEADER_BYTES - 1);

   cpr_pkg::cfg_type cfg;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;

   // packet state
   phase_type                      phase_ff, phase_in;
   logic [cpr_pkg::HDR_CNT_W-1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]                    got_magic_ff, got_magic_in;
   logic [31:0]                    got_id_ff, got_id_in;
   logic [7:0]                     got_class_ff, got_class_in;
   logic [31:0]                    got_length_ff, got_length_in;
   logic [31:0]                    got_crc_ff, got_crc_in;
   logic [15:0]                    pay_cnt_ff, pay_cnt_in;
   logic [31:0]                    run_crc_ff, run_crc_in;
   logic [15:0]                    idle_ff, idle_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   cpr_pkg::status_type  rsp_status_ff;
   logic [31:0]          rsp_id_ff;
   logic [7:0]           rsp_class_ff;
   logic [31:0]          rsp_hval_ff;
   logic [31:0]          rsp_crc_ff;

   logic                adv;
   logic                emit;
   cpr_pkg::status_type emit_status;
   logic [31:0]         emit_hval;
   logic [31:0]         emit_crc;
   logic [31:0]         crc_next;
   logic [31:0]         crc_full;
   logic [31:0]         fin;
   logic [16:0]         idle_next;
   logic [16:0]         cnt_next;

   cpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cpr_crc_step u_crc (
      .crc_in  (run_crc_ff),
      .data    (in_byte_ff),
      .crc_out (crc_next)
   );

   function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = w;
      r[pos*8 +: 8] = b;
      return r;
   endfunction

   assign adv          = in_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | adv;
   assign in_valid_in  = req_chan.valid | (in_valid_ff & ~adv);
   assign rsp_valid_in = (rsp_valid_ff & ~rsp_chan.ready) | (adv & emit);

   assign crc_full  = {in_byte_ff, got_crc_ff[23:0]};
   assign fin       = ~crc_next;
   assign idle_next = {1'b0, idle_ff} + 17'd1;
   assign cnt_next  = {1'b0, pay_cnt_ff} + 17'd1;

   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      got_magic_in  = got_magic_ff;
      got_id_in     = got_id_ff;
      got_class_in  = got_class_ff;
      got_length_in = got_length_ff;
      got_crc_in    = got_crc_ff;
      pay_cnt_in    = pay_cnt_ff;
      run_crc_in    = run_crc_ff;
      idle_in       = idle_ff;
      emit          = 1'b0;
      emit_status   = cpr_pkg::ST_OK;
      emit_hval     = got_crc_ff;
      emit_crc      = 32'd0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (!in_action_ff) begin
               case (hdr_cnt_ff) inside
                  [5'd0:5'd3]:   got_magic_in  = put_byte(got_magic_ff, hdr_cnt_ff[1:0],
                                                          in_byte_ff);
                  [5'd4:5'd7]:   got_id_in     = put_byte(got_id_ff, hdr_cnt_ff[1:0],
                                                          in_byte_ff);
                  5'd8:          got_class_in  = in_byte_ff;
                  [5'd9:5'd11]:  got_class_in  = got_class_ff;
                  [5'd12:5'd15]: got_length_in = put_byte(got_length_ff, hdr_cnt_ff[1:0],
                                                          in_byte_ff);
                  default:       got_crc_in    = put_byte(got_crc_ff, hdr_cnt_ff[1:0],
                                                          in_byte_ff);
               endcase
               if (hdr_cnt_ff != LAST_IDX) begin
                  hdr_cnt_in = hdr_cnt_ff + 1'b1;
               end else begin
                  hdr_cnt_in = '0;
                  emit_hval  = crc_full;
                  if (got_magic_ff != cfg.packet_magic) begin
                     emit        = 1'b1;
                     emit_status = cpr_pkg::ST_BAD_MAGIC;
                     emit_hval   = got_magic_ff;
                  end else if (got_class_ff > cfg.max_class) begin
                     emit        = 1'b1;
                     emit_status = cpr_pkg::ST_BAD_CLASS;
                  end else if (got_length_ff != {16'd0, cfg.payload_length}) begin
                     emit        = 1'b1;
                     emit_status = cpr_pkg::ST_BAD_LENGTH;
                  end else begin
                     run_crc_in = cpr_pkg::CRC_ALL_ONES;
                     pay_cnt_in = '0;
                     idle_in    = '0;
                     if (cfg.payload_length == 16'd0) begin
                        // empty payload: final crc is zero
                        emit        = 1'b1;
                        emit_status = (crc_full == 32'd0) ? cpr_pkg::ST_OK
                                                          : cpr_pkg::ST_CRC_MISMATCH;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            if (in_action_ff) begin
               if (idle_next > {1'b0, cfg.timeout_ticks}) begin
                  emit        = 1'b1;
                  emit_status = cpr_pkg::ST_TIMEOUT;
               end else begin
                  idle_in = idle_next[15:0];
               end
            end else begin
               run_crc_in = crc_next;
               idle_in    = '0;
               if (cnt_next >= {1'b0, cfg.payload_length}) begin
                  pay_cnt_in  = '0;
                  emit        = 1'b1;
                  emit_crc    = fin;
                  emit_status = (fin == got_crc_ff) ? cpr_pkg::ST_OK
                                                    : cpr_pkg::ST_CRC_MISMATCH;
               end else begin
                  pay_cnt_in = cnt_next[15:0];
               end
            end
         end
         default: phase_in = PH_HEADER;
      endcase

      if (emit) begin
         phase_in   = PH_HEADER;
         hdr_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_HEADER;
         hdr_cnt_ff    <= '0;
         got_magic_ff  <= '0;
         got_id_ff     <= '0;
         got_class_ff  <= '0;
         got_length_ff <= '0;
         got_crc_ff    <= '0;
         pay_cnt_ff    <= '0;
         run_crc_ff    <= cpr_pkg::CRC_ALL_ONES;
         idle_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            phase_ff      <= phase_in;
            hdr_cnt_ff    <= hdr_cnt_in;
            got_magic_ff  <= got_magic_in;
            got_id_ff     <= got_id_in;
            got_class_ff  <= got_class_in;
            got_length_ff <= got_length_in;
            got_crc_ff    <= got_crc_in;
            pay_cnt_ff    <= pay_cnt_in;
            run_crc_ff    <= run_crc_in;
            idle_ff       <= idle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_action_ff <= req_chan.action;
         in_byte_ff   <= req_chan.data_byte;
      end
      if (adv && emit) begin
         rsp_status_ff <= emit_status;
         rsp_id_ff     <= got_id_ff;
         rsp_class_ff  <= got_class_ff;
         rsp_hval_ff   <= emit_hval;
         rsp_crc_ff    <= emit_crc;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.image_id       = rsp_id_ff;
   assign rsp_chan.expected_class = rsp_class_ff;
   assign rsp_chan.header_value   = rsp_hval_ff;
   assign rsp_chan.computed_crc   = rsp_crc_ff;

endmodule
